>>> design/crcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcp_pkg: shared definitions for the framed command parser
// Sync bytes, CRC constants, result status codes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package crcp_pkg;

   // Frame delimiters and CRC-16/CCITT-FALSE settings.
   localparam logic [7:0]  SYNC_A          = 8'hAA;
   localparam logic [7:0]  SYNC_B          = 8'h55;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'h1021;

   // Default largest payload in bytes; the body adds one command id byte.
   localparam int          MAX_PAYLOAD_DEF = 64;

   // Result status codes.
   localparam logic        STATUS_OK       = 1'b0;
   localparam logic        STATUS_CRC_ERR  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic len_load;          // Take the length byte, restart CRC and write pointer.
      logic body_write;        // Store a body byte and fold it into the CRC.
      logic crc_lo_load;       // Take the low CRC byte.
      logic crc_hi_load;       // Take the high CRC byte.
      logic emit_start;        // Prefetch the first payload byte.
      logic out_load_single;   // Load the empty-payload or CRC error result.
      logic out_load_payload;  // Load the next payload result.
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic len_ok;            // Length byte lies in the legal range.
      logic body_done;         // Current body byte is the last one.
      logic crc_match;         // Received CRC equals the computed CRC.
      logic count_zero;        // Frame has no payload bytes.
      logic emit_last;         // Payload result being loaded is the final one.
      logic out_free;          // Output register can take a new beat.
   } dp_sts_type;

   // One byte step of the MSB-first CRC-16 with polynomial 0x1021.
   function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                            input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> design/crc_framed_command_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc_framed_command_parser: byte-serial command frame parser
// Finds 0xAA 0x55 frames with a length byte, body and little-endian
// CRC-16/CCITT-FALSE and returns payload, empty-payload or CRC error results.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               beat
//   req_      in          req_valid / req_stall   one received byte
//   rsp_      out         rsp_valid / rsp_stall   one payload result or error
//
// Each received byte is taken as it arrives while the frame is parsed.
// After the high CRC byte of a good frame with a payload, input is stalled
// while payload results are walked out: the first payload byte is prefetched
// from the body memory read port as the high CRC byte is taken, then one
// payload result leaves per cycle from that port unless the result side stalls.
// A stall on the result side holds the output register and, through it,
// the payload walk and the high CRC byte.
// Reset returns the parser to the sync hunt; the body memory is not cleared.
//
module crc_framed_command_parser #(
   parameter int MAX_PAYLOAD = crcp_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_rx_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_status,
   output logic [7:0]        rsp_command_id,
   output logic [6:0]        rsp_payload_count,
   output logic [5:0]        rsp_byte_index,
   output logic [7:0]        rsp_payload_byte,
   output logic [15:0]       rsp_received_crc,
   output logic [15:0]       rsp_computed_crc,
   output logic              rsp_last
);
   import crcp_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // Controller.
   crcp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .sts         (sts),
      .cmd         (cmd)
   );

   // Datapath.
   crcp_dpath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_command_id    (rsp_command_id),
      .rsp_payload_count (rsp_payload_count),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_received_crc  (rsp_received_crc),
      .rsp_computed_crc  (rsp_computed_crc),
      .rsp_last          (rsp_last)
   );

   // A result is loaded only when the output register has room.
   a_load_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load_single || cmd.out_load_payload) |-> sts.out_free)
      else $error("result loaded over a waiting beat");

   // The payload walk starts with input held off.
   a_walk_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_start |=> req_stall)
      else $error("input accepted during payload walk");

   // An error result is a single beat with an empty payload byte.
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_CRC_ERR)) |->
         (rsp_last && (rsp_payload_byte == 8'd0) && (rsp_byte_index == 6'd0)))
      else $error("malformed CRC error result");

endmodule
`default_nettype wire

>>> design/crcp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcp_ctrl: frame parser controller
// Tracks the frame phase, accepts input beats and sequences the datapath
// through length, body, CRC and payload result generation.
// ----------------------------------------------------------------------------
module crcp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_rx_byte,
   input  wire crcp_pkg::dp_sts_type  sts,
   output crcp_pkg::ctl_cmd_type      cmd
);
   import crcp_pkg::*;

   typedef enum logic [2:0] {
      ST_SYNC_A,
      ST_SYNC_B,
      ST_LENGTH,
      ST_BODY,
      ST_CRC_LO,
      ST_CRC_HI,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // Input is held off while payload results are walked out, and at the CRC
   // high byte until the output register has room for a result.
   always_comb begin
      req_stall = (state_ff == ST_EMIT) || ((state_ff == ST_CRC_HI) && !sts.out_free);
   end

   assign accept = req_valid && !req_stall;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_SYNC_A: begin
            if (accept && (req_rx_byte == SYNC_A)) begin
               state_in = ST_SYNC_B;
            end
         end
         ST_SYNC_B: begin
            if (accept) begin
               state_in = (req_rx_byte == SYNC_B) ? ST_LENGTH : ST_SYNC_A;
            end
         end
         ST_LENGTH: begin
            if (accept) begin
               if (sts.len_ok) begin
                  cmd.len_load = 1'b1;
                  state_in     = ST_BODY;
               end else begin
                  state_in = ST_SYNC_A;
               end
            end
         end
         ST_BODY: begin
            if (accept) begin
               cmd.body_write = 1'b1;
               if (sts.body_done) begin
                  state_in = ST_CRC_LO;
               end
            end
         end
         ST_CRC_LO: begin
            if (accept) begin
               cmd.crc_lo_load = 1'b1;
               state_in        = ST_CRC_HI;
            end
         end
         ST_CRC_HI: begin
            if (accept) begin
               cmd.crc_hi_load = 1'b1;
               if (sts.crc_match && !sts.count_zero) begin
                  cmd.emit_start = 1'b1;
                  state_in       = ST_EMIT;
               end else begin
                  cmd.out_load_single = 1'b1;
                  state_in            = ST_SYNC_A;
               end
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load_payload = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_SYNC_A;
               end
            end
         end
         default: begin
            state_in = ST_SYNC_A;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SYNC_A;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> design/crcp_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcp_dpath: frame parser datapath
// Holds the frame length, body memory, running CRC, received CRC, payload
// walk index and the output register of the result channel.
// ----------------------------------------------------------------------------
module crcp_dpath #(
   parameter int MAX_PAYLOAD = crcp_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             req_rx_byte,
   input  wire crcp_pkg::ctl_cmd_type  cmd,
   output crcp_pkg::dp_sts_type        sts,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_status,
   output logic [7:0]                  rsp_command_id,
   output logic [6:0]                  rsp_payload_count,
   output logic [5:0]                  rsp_byte_index,
   output logic [7:0]                  rsp_payload_byte,
   output logic [15:0]                 rsp_received_crc,
   output logic [15:0]                 rsp_computed_crc,
   output logic                        rsp_last
);
   import crcp_pkg::*;

   localparam int BODY_DEPTH = MAX_PAYLOAD + 1;
   localparam int LW         = $clog2(BODY_DEPTH + 1);
   localparam int AW         = $clog2(BODY_DEPTH);

   logic [7:0]    body_mem [BODY_DEPTH];
   logic [7:0]    mem_q_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   logic [LW-1:0] frame_len_ff;
   logic [LW-1:0] wpos_ff;
   logic [LW-1:0] emit_idx_ff;
   logic [LW-1:0] count;
   logic [LW-1:0] idx_plus2;
   logic [7:0]    count8;
   logic [7:0]    idx8;
   logic [7:0]    cmd_id_ff;
   logic [15:0]   crc_ff;
   logic [7:0]    crc_lo_ff;
   logic [15:0]   crc_rx_ff;
   logic [15:0]   crc_rx;

   logic          rsp_valid_ff;
   logic          status_ff;
   logic [7:0]    command_id_ff;
   logic [6:0]    payload_count_ff;
   logic [5:0]    byte_index_ff;
   logic [7:0]    payload_byte_ff;
   logic [15:0]   received_crc_ff;
   logic [15:0]   computed_crc_ff;
   logic          last_ff;

   // Status toward the controller.
   assign count     = frame_len_ff - LW'(1);
   assign idx_plus2 = emit_idx_ff + LW'(2);
   assign crc_rx    = {req_rx_byte, crc_lo_ff};

   always_comb begin
      sts.len_ok     = (req_rx_byte != 8'd0) && (req_rx_byte <= 8'(BODY_DEPTH));
      sts.body_done  = (LW'(wpos_ff + LW'(1)) == frame_len_ff);
      sts.crc_match  = (crc_rx == crc_ff);
      sts.count_zero = (count == '0);
      sts.emit_last  = (LW'(emit_idx_ff + LW'(1)) == count);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Frame length, write pointer, command id, CRC and walk index.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff <= '0;
         wpos_ff      <= '0;
         crc_ff       <= CRC_INIT;
      end else begin
         if (cmd.len_load) begin
            frame_len_ff <= LW'(req_rx_byte);
            wpos_ff      <= '0;
            crc_ff       <= CRC_INIT;
         end else if (cmd.body_write) begin
            wpos_ff <= wpos_ff + LW'(1);
            crc_ff  <= crc_step(crc_ff, req_rx_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.body_write && (wpos_ff == '0)) begin
         cmd_id_ff <= req_rx_byte;
      end
      if (cmd.crc_lo_load) begin
         crc_lo_ff <= req_rx_byte;
      end
      if (cmd.crc_hi_load) begin
         crc_rx_ff <= crc_rx;
      end
      if (cmd.emit_start) begin
         emit_idx_ff <= '0;
      end else if (cmd.out_load_payload) begin
         emit_idx_ff <= emit_idx_ff + LW'(1);
      end
   end

   // Body memory: one write port, one registered read port that walks ahead
   // of the output register by one payload byte.
   assign rd_en   = cmd.emit_start || (cmd.out_load_payload && !sts.emit_last);
   assign rd_addr = cmd.emit_start ? AW'(1) : idx_plus2[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.body_write) begin
         body_mem[wpos_ff[AW-1:0]] <= req_rx_byte;
      end
      if (rd_en) begin
         mem_q_ff <= body_mem[rd_addr];
      end
   end

   // Output register of the result channel.
   assign count8 = 8'(count);
   assign idx8   = 8'(emit_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load_single || cmd.out_load_payload) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load_single) begin
         status_ff        <= sts.crc_match ? STATUS_OK : STATUS_CRC_ERR;
         payload_count_ff <= count8[6:0];
         byte_index_ff    <= '0;
         payload_byte_ff  <= '0;
         received_crc_ff  <= crc_rx;
         last_ff          <= 1'b1;
      end else if (cmd.out_load_payload) begin
         status_ff        <= STATUS_OK;
         payload_count_ff <= count8[6:0];
         byte_index_ff    <= idx8[5:0];
         payload_byte_ff  <= mem_q_ff;
         received_crc_ff  <= crc_rx_ff;
         last_ff          <= sts.emit_last;
      end
   end

   // Command id and computed CRC are captured with each result beat.
   always_ff @(posedge clock) begin
      if (cmd.out_load_single || cmd.out_load_payload) begin
         command_id_ff   <= cmd_id_ff;
         computed_crc_ff <= crc_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_command_id    = command_id_ff;
   assign rsp_payload_count = payload_count_ff;
   assign rsp_byte_index    = byte_index_ff;
   assign rsp_payload_byte  = payload_byte_ff;
   assign rsp_received_crc  = received_crc_ff;
   assign rsp_computed_crc  = computed_crc_ff;
   assign rsp_last          = last_ff;

endmodule
`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for crc_framed_command_parser
// Drives received bytes into the parser as framed commands, broken frames and
// line noise. A built-in frame tracker predicts every payload and CRC error
// result, and each result beat is compared field by field against it. Random
// idle gaps on the sender and random stalls on the result side move the
// timing around every phase of the parse and the payload walk.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import crcp_pkg::*;

   localparam int MAX_PAYLOAD  = MAX_PAYLOAD_DEF;
   localparam int BODY_DEPTH   = MAX_PAYLOAD + 1;
   localparam int RANDOM_BEATS = 90;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_LIMIT = 10;

   // Parse phases of the frame tracker.
   typedef enum logic [2:0] {
      HUNT_A, HUNT_B, GET_LENGTH, GET_BODY, GET_CRC_LO, GET_CRC_HI
   } parse_phase_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  command_id;
      logic [6:0]  payload_count;
      logic [5:0]  byte_index;
      logic [7:0]  payload_byte;
      logic [15:0] received_crc;
      logic [15:0] computed_crc;
      logic        last;
   } frame_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_status;
   logic [7:0]  rsp_command_id;
   logic [6:0]  rsp_payload_count;
   logic [5:0]  rsp_byte_index;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_received_crc;
   logic [15:0] rsp_computed_crc;
   logic        rsp_last;

   // Frame tracker state.
   parse_phase_type tracked_phase;
   logic [6:0]      tracked_length;
   logic [7:0]      tracked_body [BODY_DEPTH];
   logic [6:0]      tracked_position;
   logic [15:0]     tracked_crc;
   logic [15:0]     tracked_frame_crc;

   frame_result_type pending_results [$];
   logic [7:0]       frame_payload [$];

   bit sender_idles;
   bit receiver_idles;
   int mismatch_count;
   int results_checked;
   int crc_errors_seen;
   int frames_sent;
   int frame_beats;
   int quiet_cycles;

   crc_framed_command_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_command_id    (rsp_command_id),
      .rsp_payload_count (rsp_payload_count),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_received_crc  (rsp_received_crc),
      .rsp_computed_crc  (rsp_computed_crc),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // CRC-16/CCITT-FALSE, one message bit at a time, MSB first.
   function automatic logic [15:0] crc16_fold(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] acc;
      logic        feedback;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = acc[15] ^ data[i];
         acc = {acc[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
      end
      return acc;
   endfunction

   function automatic frame_result_type make_result(input logic status,
                                                    input logic [5:0] index,
                                                    input logic [7:0] value,
                                                    input logic last);
      frame_result_type r;
      r.status        = status;
      r.command_id    = tracked_body[0];
      r.payload_count = tracked_length - 7'd1;
      r.byte_index    = index;
      r.payload_byte  = value;
      r.received_crc  = tracked_frame_crc;
      r.computed_crc  = tracked_crc;
      r.last          = last;
      return r;
   endfunction

   function automatic void return_to_hunt();
      tracked_phase     = HUNT_A;
      tracked_length    = '0;
      tracked_position  = '0;
      tracked_frame_crc = '0;
   endfunction

   // Advance the frame tracker by one accepted byte and queue its results.
   function automatic void track_rx_byte(input logic [7:0] value);
      int count;
      case (tracked_phase)
         HUNT_A: begin
            if (value == SYNC_A) tracked_phase = HUNT_B;
         end
         HUNT_B: begin
            tracked_phase = (value == SYNC_B) ? GET_LENGTH : HUNT_A;
         end
         GET_LENGTH: begin
            if (value == 8'd0 || value > BODY_DEPTH) begin
               return_to_hunt();
            end else begin
               tracked_length   = value[6:0];
               tracked_position = '0;
               tracked_crc      = CRC_INIT;
               tracked_phase    = GET_BODY;
            end
         end
         GET_BODY: begin
            tracked_body[tracked_position] = value;
            tracked_crc = crc16_fold(tracked_crc, value);
            tracked_position++;
            if (tracked_position >= tracked_length) tracked_phase = GET_CRC_LO;
         end
         GET_CRC_LO: begin
            tracked_frame_crc = {8'h00, value};
            tracked_phase     = GET_CRC_HI;
         end
         GET_CRC_HI: begin
            tracked_frame_crc[15:8] = value;
            if (tracked_frame_crc == tracked_crc) begin
               count = tracked_length - 1;
               if (count == 0) begin
                  pending_results.push_back(make_result(STATUS_OK, 6'd0, 8'h00, 1'b1));
               end else begin
                  for (int i = 0; i < count; i++) begin
                     pending_results.push_back(make_result(STATUS_OK, i[5:0],
                        tracked_body[i + 1], i == count - 1));
                  end
               end
            end else begin
               pending_results.push_back(make_result(STATUS_CRC_ERR, 6'd0, 8'h00, 1'b1));
            end
            return_to_hunt();
         end
         default: return_to_hunt();
      endcase
   endfunction

   // Send one byte beat, after a random idle gap when the sender idles; track it once accepted.
   task automatic send_rx(input logic [7:0] value);
      int gap;
      gap = sender_idles ? $urandom_range(0, 19) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_stall);
      track_rx_byte(value);
   endtask

   // Send a complete frame around frame_payload; optionally spoil its CRC.
   task automatic send_frame(input logic [7:0] command, input bit spoil_crc);
      logic [15:0] crc;
      crc = crc16_fold(CRC_INIT, command);
      foreach (frame_payload[i]) crc = crc16_fold(crc, frame_payload[i]);
      if (spoil_crc) crc ^= 16'(1 << $urandom_range(0, 15));
      send_rx(SYNC_A);
      send_rx(SYNC_B);
      send_rx(8'(frame_payload.size() + 1));
      send_rx(command);
      foreach (frame_payload[i]) send_rx(frame_payload[i]);
      send_rx(crc[7:0]);
      send_rx(crc[15:8]);
      frames_sent++;
      frame_beats += frame_payload.size() + 6;
   endtask

   task automatic fill_payload(input int count);
      frame_payload.delete();
      repeat (count) frame_payload.push_back(8'($urandom));
   endtask

   // Hold the sender off until every expected result has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input bit sender, input bit receiver);
      sender_idles   = sender;
      receiver_idles = receiver;
   endtask

   // A second sync byte that misses returns to the hunt without rechecking it.
   task automatic test_sync_hunt();
      set_idling(1'b0, 1'b0);
      send_rx(8'h00);
      send_rx(SYNC_A);
      send_rx(SYNC_A);
      send_rx(SYNC_B);
      send_rx(8'h55);
   endtask

   // A length of one carries only the command id and yields one result.
   task automatic test_empty_payload();
      set_idling(1'b1, 1'b1);
      frame_payload.delete();
      send_frame(8'hFF, 1'b0);
   endtask

   // Length zero and one past the largest body both drop back to the hunt.
   task automatic test_bad_length();
      send_rx(SYNC_A);
      send_rx(SYNC_B);
      send_rx(8'd0);
      send_rx(SYNC_A);
      send_rx(SYNC_B);
      send_rx(8'(BODY_DEPTH + 1));
   endtask

   // A corrupted CRC gives a single error beat; the sender then waits it out.
   task automatic test_crc_error();
      frame_payload = '{8'h80};
      send_frame(8'h00, 1'b1);
      wait_for_drain();
   endtask

   // Payload bytes at both ends of their range.
   task automatic test_payload_extremes();
      set_idling(1'b0, 1'b1);
      frame_payload = '{8'h00, 8'hFF};
      send_frame(8'h00, 1'b0);
   endtask

   // Mostly well-formed frames with random content, some broken ones and noise.
   task automatic test_random_traffic();
      int start_beats;
      int pick;
      logic [7:0] value;
      start_beats = frame_beats;
      set_idling(1'b1, 1'b1);
      fill_payload(MAX_PAYLOAD);
      send_frame(8'($urandom), 1'b0);
      while (frame_beats - start_beats < RANDOM_BEATS) begin
         if ($urandom_range(0, 3) == 0)
            set_idling($urandom_range(0, 1), $urandom_range(0, 1));
         pick = $urandom_range(0, 19);
         if (pick < 16) begin
            fill_payload(($urandom_range(0, 9) == 0) ? $urandom_range(8, MAX_PAYLOAD)
                                                     : $urandom_range(0, 6));
            send_frame(8'($urandom), pick >= 13);
         end else if (pick == 16) begin
            send_rx(SYNC_A);
            send_rx(SYNC_B);
            send_rx(($urandom_range(0, 1) == 0) ? 8'd0
                                               : 8'($urandom_range(BODY_DEPTH + 1, 255)));
         end else if (pick == 17) begin
            value = 8'($urandom);
            if (value == SYNC_B) value = 8'h00;
            send_rx(SYNC_A);
            send_rx(value);
         end else begin
            repeat ($urandom_range(1, 3)) begin
               value = 8'($urandom);
               if (value == SYNC_A) value = 8'h00;
               send_rx(value);
            end
         end
         if ($urandom_range(0, 7) == 0) wait_for_drain();
      end
   endtask

   // Result side: when the receiver idles, stall for a random hold before each beat.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         hold = receiver_idles ? $urandom_range(0, 19) : 0;
         @(negedge clock);
         rsp_stall <= (hold > 0);
         if (hold > 0) begin
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Compare every accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_command_id, rsp_payload_count, rsp_byte_index,
                 rsp_payload_byte, rsp_received_crc, rsp_computed_crc, rsp_last};
         results_checked++;
         if (got.status == STATUS_CRC_ERR) crc_errors_seen++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("[%0t] unexpected result beat: %p", $realtime, got);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.command_id !== want.command_id ||
                got.payload_count !== want.payload_count ||
                got.byte_index !== want.byte_index ||
                got.payload_byte !== want.payload_byte ||
                got.received_crc !== want.received_crc ||
                got.computed_crc !== want.computed_crc || got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("[%0t] result mismatch", $realtime);
                  $display("   expected %p", want);
                  $display("   actual   %p", got);
               end
            end
         end
      end
   end

   // Watchdog: end the run if no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[%0t] no beat accepted for %0d cycles", $realtime, STALL_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_byte  = 8'h00;
      quiet_cycles = 0;
      mismatch_count  = 0;
      results_checked = 0;
      crc_errors_seen = 0;
      frames_sent     = 0;
      frame_beats     = 0;
      sender_idles    = 1'b0;
      receiver_idles  = 1'b0;
      return_to_hunt();
      tracked_crc = CRC_INIT;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_sync_hunt();
      test_empty_payload();
      test_bad_length();
      test_crc_error();
      test_payload_extremes();
      test_random_traffic();

      // Let the last results drain, then watch for stray beats.
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         mismatch_count++;
         $display("%0d expected results never arrived", pending_results.size());
      end

      $display("Sent %0d frames plus broken frames and noise; checked %0d result beats,",
               frames_sent, results_checked);
      $display("%0d of them CRC errors, with %0d mismatches.", crc_errors_seen,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
